// ===== sv/lpr_pkg.sv =====
// Shared types, constants and helpers for the line pixel rasterizer.
// Used by lpr_front, lpr_queue, lpr_back and line_pixel_rasterizer.
package lpr_pkg;

  localparam int COORD_W     = 5;
  localparam int Y_W         = 7;
  localparam int ERR_W       = 8;
  localparam int MAX_PIX     = 64;
  localparam int CNT_W       = $clog2(MAX_PIX);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(31);

  typedef enum logic [1:0] {
    MODE_VERT,
    MODE_HORZ,
    MODE_DIAG
  } lpr_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } lpr_state_t;

  // One classified segment, endpoints ordered for the walker.
  typedef struct packed {
    lpr_mode_t          mode;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] ady;
    logic               neg;
  } lpr_job_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

// ===== sv/lpr_front.sv =====
// Front end: saturates and orders the endpoints of a segment and classifies it.
// Depends on lpr_pkg.
module lpr_front (
  input  logic [lpr_pkg::COORD_W-1:0] x_start,
  input  logic [lpr_pkg::COORD_W-1:0] y_start,
  input  logic [lpr_pkg::COORD_W-1:0] x_end,
  input  logic [lpr_pkg::COORD_W-1:0] y_end,
  output lpr_pkg::lpr_job_t           job
);

  logic [lpr_pkg::COORD_W-1:0] xa, ya, xb, yb;
  logic [lpr_pkg::COORD_W-1:0] x0, y0, x1, y1;
  logic [lpr_pkg::COORD_W-1:0] dx, ady;
  logic                        neg;

  always_comb begin
    xa = lpr_pkg::clamp_coord(x_start);
    ya = lpr_pkg::clamp_coord(y_start);
    xb = lpr_pkg::clamp_coord(x_end);
    yb = lpr_pkg::clamp_coord(y_end);
    if (xa > xb) begin
      x0 = xb; y0 = yb; x1 = xa; y1 = ya;
    end else begin
      x0 = xa; y0 = ya; x1 = xb; y1 = yb;
    end
    dx  = x1 - x0;
    neg = (y1 < y0);
    ady = neg ? (y0 - y1) : (y1 - y0);

    job.x0  = x0;
    job.x1  = x1;
    job.dx  = dx;
    job.ady = ady;
    job.neg = neg;
    job.y0  = y0;
    job.y1  = y1;
    if (dx == '0) begin
      // A vertical run always walks upward from the lower y.
      job.mode = lpr_pkg::MODE_VERT;
      job.y0   = neg ? y1 : y0;
      job.y1   = neg ? y0 : y1;
    end else if (ady == '0) begin
      job.mode = lpr_pkg::MODE_HORZ;
    end else begin
      job.mode = lpr_pkg::MODE_DIAG;
    end
  end

endmodule

// ===== sv/lpr_queue.sv =====
// Short queue of classified segments between the front end and the walker.
// Depends on lpr_pkg.
module lpr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpr_pkg::lpr_job_t push_job,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output lpr_pkg::lpr_job_t pop_job
);

  lpr_pkg::lpr_job_t                mem [lpr_pkg::QUEUE_DEPTH];
  logic [lpr_pkg::QPTR_W-1:0]       wr_ptr;
  logic [lpr_pkg::QPTR_W-1:0]       rd_ptr;
  logic [lpr_pkg::QCNT_W-1:0]       count;

  assign not_full  = (count != lpr_pkg::QCNT_W'(lpr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lpr_pkg::QPTR_W'(lpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lpr_pkg::QPTR_W'(lpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= lpr_pkg::QCNT_W'(lpr_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue fill count missed a pop");

endmodule

// ===== sv/lpr_back.sv =====
// Back end: walks the pixels of one classified segment, one per cycle while
// out_ready does not stall it, into an output register. Depends on lpr_pkg.
module lpr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  lpr_pkg::lpr_job_t           job,
  output logic                        job_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpr_pkg::COORD_W-1:0] out_x,
  output logic signed [lpr_pkg::Y_W-1:0] out_y,
  output logic                        out_last
);

  lpr_pkg::lpr_state_t                state, state_next;
  lpr_pkg::lpr_mode_t                 mode;
  logic [lpr_pkg::COORD_W-1:0]        x, x_next, x_stop, emit_x;
  logic signed [lpr_pkg::Y_W-1:0]     y, y_next, y_step;
  logic [lpr_pkg::COORD_W-1:0]        y_stop;
  logic [lpr_pkg::COORD_W-1:0]        dx, ady;
  logic                               neg;
  logic signed [lpr_pkg::ERR_W-1:0]   e, e_next, dx_s, two_dx, two_ady;
  logic                               first;
  logic [lpr_pkg::CNT_W-1:0]          count;
  logic                               adv, done, emit_last;

  assign adv = (state == lpr_pkg::ST_WALK) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        if (job_valid) state_next = lpr_pkg::ST_WALK;
      end
      lpr_pkg::ST_WALK: begin
        if (adv && emit_last) state_next = lpr_pkg::ST_IDLE;
      end
      default: state_next = lpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (state == lpr_pkg::ST_IDLE) && job_valid;
  end

  always_comb begin
    dx_s    = $signed({{(lpr_pkg::ERR_W - lpr_pkg::COORD_W){1'b0}}, dx});
    two_dx  = $signed({{(lpr_pkg::ERR_W - lpr_pkg::COORD_W - 1){1'b0}}, dx, 1'b0});
    two_ady = $signed({{(lpr_pkg::ERR_W - lpr_pkg::COORD_W - 1){1'b0}}, ady, 1'b0});
    y_step  = neg ? -lpr_pkg::Y_W'(1) : lpr_pkg::Y_W'(1);
    emit_x  = x;
    x_next  = x;
    y_next  = y;
    e_next  = e;
    done    = 1'b0;
    case (mode)
      lpr_pkg::MODE_VERT: begin
        y_next = y + lpr_pkg::Y_W'(1);
        done   = (y == $signed({2'b00, y_stop}));
      end
      lpr_pkg::MODE_HORZ: begin
        x_next = x + 1'b1;
        done   = (x == x_stop);
      end
      default: begin
        // While the error sits at or above one half, repeat the pixel and
        // step y; otherwise move on to the next column.
        if (e >= dx_s) begin
          y_next = y + y_step;
          e_next = e - two_dx;
        end else begin
          emit_x = first ? x : x + 1'b1;
          e_next = e + two_ady;
        end
        x_next = emit_x;
        done   = (emit_x == x_stop) && (e_next < dx_s);
      end
    endcase
    emit_last = done || (&count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      mode   <= job.mode;
      x      <= job.x0;
      y      <= $signed({2'b00, job.y0});
      x_stop <= job.x1;
      y_stop <= job.y1;
      dx     <= job.dx;
      ady    <= job.ady;
      neg    <= job.neg;
      e      <= '0;
      first  <= 1'b1;
      count  <= '0;
    end else if (adv) begin
      x     <= x_next;
      y     <= y_next;
      e     <= e_next;
      first <= 1'b0;
      count <= count + 1'b1;
    end
    if (adv) begin
      out_x    <= emit_x;
      out_y    <= y;
      out_last <= emit_last;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_WALK && out_valid && !out_ready)
      |=> ($stable(count) && $stable(state)))
    else $error("walker advanced while the output register was stalled");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_WALK && mode == lpr_pkg::MODE_DIAG)
      |-> (e >= -lpr_pkg::ERR_W'(32) && e <= lpr_pkg::ERR_W'(93)))
    else $error("error term out of range");

  a_vert_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_WALK && mode == lpr_pkg::MODE_VERT)
      |-> (y <= $signed({2'b00, y_stop})))
    else $error("vertical walk passed its end");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == lpr_pkg::ST_WALK && first && count == '0))
    else $error("segment load did not start a fresh walk");

endmodule

// ===== sv/line_pixel_rasterizer.sv =====
// A segment accepted into the two-entry segment queue is loaded into the
// walker once it is idle, and its first pixel is then registered on the
// output; pixels follow one per cycle while m_tready does not stall them.
// A segment of n pixels (n up to 64) holds the walker until its last pixel.
// Reset (rst, synchronous) empties the queue, idles the walker and the output.
module line_pixel_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_start[4:0], y_start[9:5], x_end[14:10], y_end[19:15], zero[23:20]
  input  logic [lpr_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_x[4:0], pixel_y[11:5] (signed), zero[15:12]
  output logic [lpr_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tlast
);

  localparam int CW = lpr_pkg::COORD_W;

  lpr_pkg::lpr_job_t               front_job, queue_job;
  logic                            q_not_full, q_not_empty, q_pop;
  logic [CW-1:0]                   pixel_x;
  logic signed [lpr_pkg::Y_W-1:0]  pixel_y;

  lpr_front u_front (
    .x_start (s_tdata[CW-1:0]),
    .y_start (s_tdata[2*CW-1:CW]),
    .x_end   (s_tdata[3*CW-1:2*CW]),
    .y_end   (s_tdata[4*CW-1:3*CW]),
    .job     (front_job)
  );

  assign s_tready = q_not_full;

  lpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && q_not_full),
    .push_job  (front_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (queue_job)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job       (queue_job),
    .job_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (pixel_x),
    .out_y     (pixel_y),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(lpr_pkg::M_TDATA_W - CW - lpr_pkg::Y_W){1'b0}}, pixel_y, pixel_x};

endmodule

// ===== tb/tb_line_pixel_rasterizer.sv =====
// Self-checking testbench for line_pixel_rasterizer: segments go in on the
// slave stream, and every pixel on the master stream is checked against a
// local Bresenham-style walker. Depends on lpr_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_line_pixel_rasterizer;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 420;
  localparam int TAIL_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [lpr_pkg::COORD_W-1:0] x;
    logic [lpr_pkg::Y_W-1:0]     y;
    logic                        last;
  } pixel_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // x_start[4:0], y_start[9:5], x_end[14:10], y_end[19:15], zero[23:20]
  logic [lpr_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // pixel_x[4:0], pixel_y[11:5] (signed), zero[15:12]
  logic [lpr_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tlast;

  pixel_t expected_pixels[$];
  int     error_count = 0;
  int     segments_sent = 0;
  int     pixels_checked = 0;
  int     runs_checked = 0;
  bit     src_idle_en = 1'b0;
  bit     sink_stall_en = 1'b0;

  line_pixel_rasterizer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Appends one pixel to a run unless the run has reached its length limit.
  function automatic void add_pixel(ref pixel_t run[$], input int x, input int y);
    pixel_t p;
    if (run.size() < lpr_pkg::MAX_PIX) begin
      p.x    = lpr_pkg::COORD_W'(x);
      p.y    = lpr_pkg::Y_W'(y);
      p.last = 1'b0;
      run.insert(run.size(), p);
    end
  endfunction

  // Walks one segment and appends its pixel run to the expected pixels.
  task automatic rasterize(input logic [lpr_pkg::COORD_W-1:0] xs, ys, xe, ye);
    int     x0, y0, x1, y1, t, dx, dy, ady, step, x, y, err;
    pixel_t run[$];
    x0 = int'((xs > lpr_pkg::COORD_MAX) ? lpr_pkg::COORD_MAX : xs);
    y0 = int'((ys > lpr_pkg::COORD_MAX) ? lpr_pkg::COORD_MAX : ys);
    x1 = int'((xe > lpr_pkg::COORD_MAX) ? lpr_pkg::COORD_MAX : xe);
    y1 = int'((ye > lpr_pkg::COORD_MAX) ? lpr_pkg::COORD_MAX : ye);
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    if (dx == 0) begin
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
      end
      for (y = y0; y <= y1; y++)
        add_pixel(run, x0, y);
    end else if (dy == 0) begin
      for (x = x0; x <= x1; x++)
        add_pixel(run, x, y0);
    end else begin
      ady  = (dy < 0) ? -dy : dy;
      step = (dy > 0) ? 1 : -1;
      y    = y0;
      err  = 0;
      for (x = x0; x <= x1; x++) begin
        add_pixel(run, x, y);
        err += 2 * ady;
        // Each crossing of one half repeats the pixel before y moves.
        while (err >= dx) begin
          add_pixel(run, x, y);
          y   += step;
          err -= 2 * dx;
        end
      end
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_pixels.insert(expected_pixels.size(), run[i]);
  endtask

  task automatic send_segment(input logic [lpr_pkg::COORD_W-1:0] xs, ys, xe, ye);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, ye, xe, ys, xs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rasterize(xs, ys, xe, ye);
    segments_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_segment(5'd0, 5'd0, 5'd0, 5'd0);
    send_segment(5'd31, 5'd31, 5'd31, 5'd31);
    send_segment(5'd5, 5'd0, 5'd5, 5'd31);
    send_segment(5'd5, 5'd31, 5'd5, 5'd0);
    send_segment(5'd0, 5'd7, 5'd31, 5'd7);
    send_segment(5'd31, 5'd7, 5'd0, 5'd7);
    send_segment(5'd0, 5'd0, 5'd31, 5'd31);
    send_segment(5'd0, 5'd31, 5'd31, 5'd0);
    send_segment(5'd31, 5'd0, 5'd0, 5'd31);
    send_segment(5'd0, 5'd0, 5'd1, 5'd31);
    send_segment(5'd0, 5'd31, 5'd1, 5'd0);
    send_segment(5'd4, 5'd0, 5'd3, 5'd31);
    send_segment(5'd0, 5'd0, 5'd31, 5'd1);
    send_segment(5'd31, 5'd30, 5'd0, 5'd31);
    send_segment(5'd10, 5'd10, 5'd11, 5'd11);
    send_segment(5'd31, 5'd0, 5'd31, 5'd0);
    send_segment(5'd20, 5'd3, 5'd26, 5'd14);
    send_segment(5'd26, 5'd14, 5'd20, 5'd3);
  endtask

  // Holds the sender until the walker has emptied, then restarts it cold.
  task automatic test_drain_pause();
    send_segment(5'd2, 5'd29, 5'd30, 5'd1);
    send_segment(5'd17, 5'd17, 5'd17, 5'd17);
    wait_drained();
    send_segment(5'd9, 5'd0, 5'd12, 5'd31);
  endtask

  task automatic send_random_segment();
    logic [lpr_pkg::COORD_W-1:0] xs, ys, xe, ye;
    int                          shape;
    xs = lpr_pkg::COORD_W'($urandom_range(0, 31));
    ys = lpr_pkg::COORD_W'($urandom_range(0, 31));
    xe = lpr_pkg::COORD_W'($urandom_range(0, 31));
    ye = lpr_pkg::COORD_W'($urandom_range(0, 31));
    shape = $urandom_range(0, 9);
    case (shape)
      0: xe = xs;
      1: ye = ys;
      2: begin
        xe = xs;
        ye = ys;
      end
      3: xe = (xs > 5'd29) ? xs - 5'd1 : xs + 5'd1;
      4: begin
        xs = ($urandom_range(0, 1) == 1) ? 5'd31 : 5'd0;
        xe = ~xs;
      end
      default: ;
    endcase
    send_segment(xs, ys, xe, ye);
  endtask

  task automatic test_random();
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) send_random_segment();
  endtask

  task automatic test_full_rate();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) send_random_segment();
  endtask

  initial begin : ready_gen
    int n;
    forever begin
      @(posedge clk);
      if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_t                      want;
    logic [lpr_pkg::COORD_W-1:0] got_x;
    logic [lpr_pkg::Y_W-1:0]     got_y;
    if (!rst && m_tvalid && m_tready) begin
      got_x = m_tdata[lpr_pkg::COORD_W-1:0];
      got_y = m_tdata[lpr_pkg::COORD_W+lpr_pkg::Y_W-1:lpr_pkg::COORD_W];
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d last=%0b",
                 $time, got_x, $signed(got_y), m_tlast);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got_x !== want.x) begin
          $display("%0t: pixel_x mismatch, expected %0d, actual %0d", $time, want.x, got_x);
          error_count++;
        end
        if (got_y !== want.y) begin
          $display("%0t: pixel_y mismatch, expected %0d, actual %0d",
                   $time, $signed(want.y), $signed(got_y));
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_pixel mismatch, expected %0b, actual %0b",
                   $time, want.last, m_tlast);
          error_count++;
        end
        if (want.last) runs_checked++;
      end
      pixels_checked++;
    end
  end

  // Ends a hung run: counts consecutive cycles with no item on either side.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random();
    test_full_rate();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
      error_count++;
    end
    $display("Covered %0d segments (points, vertical, horizontal, shallow, steep, swapped)",
             segments_sent);
    $display("and %0d pixels in %0d runs, with random idling and a full-rate tail.",
             pixels_checked, runs_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
